@@ hw/rtl/dsvs_pkg.sv @@
// Shared types and constants for the DSatur vertex selector.
package dsvs_pkg;

    localparam int NUM_V   = 64;
    localparam int VW      = 6;
    localparam int DEGW    = 7;
    localparam int SATW    = 7;
    localparam int DSW     = DEGW + SATW;
    localparam int COLW    = 6;
    localparam int OPW     = 3;

    localparam logic [VW-1:0] LAST_V = VW'(NUM_V - 1);

    typedef enum logic [OPW-1:0] {
        OP_CLEAR  = 3'd0,
        OP_ADD_V  = 3'd1,
        OP_EDGE   = 3'd2,
        OP_COLOR  = 3'd3,
        OP_SELECT = 3'd4
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_E_RDV,
        S_E_WRV,
        S_E_WRW,
        S_R_ROW,
        S_R_LATCH,
        S_R_SCAN,
        S_R_TAIL,
        S_R_WR,
        S_C_RD,
        S_C_LATCH,
        S_C_SCAN,
        S_C_NEXT,
        S_S_SCAN,
        S_S_TAIL,
        S_FIN
    } t_state;

    // where a saturation recompute returns to
    typedef enum logic [1:0] {
        RET_EDGE_V,
        RET_EDGE_W,
        RET_COLOR
    } t_ret;

endpackage

@@ hw/rtl/dsvs_ram.sv @@
// Generic simple dual-port RAM, one write port, one registered read port.
module dsvs_ram #(
    parameter int W = 8,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/dsatur_vertex_selector_unit.sv @@
// Top level of the DSatur vertex selector: graph state and sequencer.
//
// Usage:
//  - Slave channel (i_s_*) carries one command per transfer: the operation
//    in tuser, vertex / neighbor / color in tdata. o_s_tready is high only
//    while the sequencer is idle; a command is worked on alone.
//  - Master channel (o_m_*) returns exactly one result per command:
//    selected vertex in tdata, found / all-colored flags in tuser.
//  - The single sequencer walks through the memories: each degree/saturation
//    scan and each saturation recompute take one vertex per cycle. Clear, add
//    vertex and the no-op codes need no scan; select makes one scan of
//    degree/saturation; add edge runs a saturation recompute per uncolored
//    endpoint; color vertex walks its neighbor row and runs one per uncolored
//    neighbor. A saturation recompute reads every vertex color through one
//    port.
//  - The result sits in an output register; if the receiver stalls the
//    sequencer waits in its final state until that register frees up.
//  - Reset (i_rst_n low, synchronous) empties the graph: valid bits of the
//    adjacency and degree/saturation memories drop, so no clearing pass is
//    needed. The clear command does the same.
module dsatur_vertex_selector_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [5:0] vertex, [11:6] neighbor, [17:12] color
    input  logic [2:0]  i_s_tuser,   // [2:0] operation
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [5:0] selected_vertex
    output logic [1:0]  o_m_tuser    // [0] vertex_found, [1] all_colored
);

    localparam int NV   = dsvs_pkg::NUM_V;
    localparam int VW   = dsvs_pkg::VW;
    localparam int DSW  = dsvs_pkg::DSW;
    localparam int SATW = dsvs_pkg::SATW;
    localparam int DEGW = dsvs_pkg::DEGW;
    localparam int COLW = dsvs_pkg::COLW;

    dsvs_pkg::t_state r_state, n_state;
    dsvs_pkg::t_ret   r_ret, n_ret;

    // input fields
    logic [VW-1:0]   in_v, in_w;
    logic [COLW-1:0] in_c;
    logic [2:0]      in_op;
    logic            acc;

    assign in_v  = i_s_tdata[5:0];
    assign in_w  = i_s_tdata[11:6];
    assign in_c  = i_s_tdata[17:12];
    assign in_op = i_s_tuser;
    assign acc   = i_s_tvalid && o_s_tready;

    // control state
    logic [NV-1:0] r_present, n_present;
    logic [NV-1:0] r_colored, n_colored;
    logic [NV-1:0] r_adj_vld, n_adj_vld;
    logic [NV-1:0] r_ds_vld,  n_ds_vld;
    logic          r_out_valid, n_out_valid;

    // datapath
    logic [VW-1:0]   r_v, n_v, r_w, n_w;
    logic [VW-1:0]   r_idx, n_idx;
    logic [VW-1:0]   r_outer, n_outer;
    logic [VW-1:0]   r_tgt, n_tgt;
    logic [NV-1:0]   r_row, n_row;
    logic [NV-1:0]   r_nbrs, n_nbrs;
    logic [NV-1:0]   r_seen, n_seen;
    logic [SATW-1:0] r_cnt, n_cnt;
    logic            r_q, n_q, r_qv, n_qv;
    logic [VW-1:0]   r_qi, n_qi;
    logic            r_dup, n_dup;
    logic            r_found, n_found;
    logic [VW-1:0]   r_best, n_best;
    logic [SATW-1:0] r_bsat, n_bsat;
    logic [DEGW-1:0] r_bdeg, n_bdeg;
    logic [VW-1:0]   r_sel, n_sel;
    logic            r_ofound, n_ofound;
    logic            r_oall, n_oall;

    // memory ports
    logic            adj_we, ds_we, col_we;
    logic [VW-1:0]   adj_waddr, adj_raddr, ds_waddr, ds_raddr, col_waddr, col_raddr;
    logic [NV-1:0]   adj_wdata, adj_rdata, adj_row;
    logic [DSW-1:0]  ds_wdata, ds_rdata, ds_word;
    logic [COLW-1:0] col_wdata, col_rdata;
    logic            r_adj_rv, r_ds_rv;

    dsvs_ram #(.W(NV), .D(NV)) u_adj (
        .i_clk(i_clk), .i_we(adj_we), .i_waddr(adj_waddr), .i_wdata(adj_wdata),
        .i_raddr(adj_raddr), .o_rdata(adj_rdata)
    );

    dsvs_ram #(.W(DSW), .D(NV)) u_ds (
        .i_clk(i_clk), .i_we(ds_we), .i_waddr(ds_waddr), .i_wdata(ds_wdata),
        .i_raddr(ds_raddr), .o_rdata(ds_rdata)
    );

    dsvs_ram #(.W(COLW), .D(NV)) u_col (
        .i_clk(i_clk), .i_we(col_we), .i_waddr(col_waddr), .i_wdata(col_wdata),
        .i_raddr(col_raddr), .o_rdata(col_rdata)
    );

    // entries never written since clear read as zero
    assign adj_row = r_adj_rv ? adj_rdata : '0;
    assign ds_word = r_ds_rv  ? ds_rdata  : '0;

    logic [SATW-1:0] cand_sat;
    logic [DEGW-1:0] cand_deg;
    logic            out_free;

    assign cand_sat = ds_word[SATW-1:0];
    assign cand_deg = ds_word[DSW-1:SATW];
    assign out_free = !r_out_valid || i_m_tready;

    assign o_s_tready = (r_state == dsvs_pkg::S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_sel};
    assign o_m_tuser  = {r_oall, r_ofound};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dsvs_pkg::S_IDLE: begin
                if (acc) begin
                    case (in_op)
                        dsvs_pkg::OP_EDGE:
                            n_state = (in_v != in_w) ? dsvs_pkg::S_E_RDV : dsvs_pkg::S_FIN;
                        dsvs_pkg::OP_COLOR:
                            n_state = r_present[in_v] ? dsvs_pkg::S_C_RD : dsvs_pkg::S_FIN;
                        dsvs_pkg::OP_SELECT:
                            n_state = dsvs_pkg::S_S_SCAN;
                        default:
                            n_state = dsvs_pkg::S_FIN;
                    endcase
                end
            end
            dsvs_pkg::S_E_RDV: n_state = dsvs_pkg::S_E_WRV;
            dsvs_pkg::S_E_WRV: n_state = dsvs_pkg::S_E_WRW;
            dsvs_pkg::S_E_WRW: begin
                if (!r_colored[r_v] || !r_colored[r_w]) begin
                    n_state = dsvs_pkg::S_R_ROW;
                end else begin
                    n_state = dsvs_pkg::S_FIN;
                end
            end
            dsvs_pkg::S_R_ROW:   n_state = dsvs_pkg::S_R_LATCH;
            dsvs_pkg::S_R_LATCH: n_state = dsvs_pkg::S_R_SCAN;
            dsvs_pkg::S_R_SCAN: begin
                if (r_idx == dsvs_pkg::LAST_V) begin
                    n_state = dsvs_pkg::S_R_TAIL;
                end
            end
            dsvs_pkg::S_R_TAIL: n_state = dsvs_pkg::S_R_WR;
            dsvs_pkg::S_R_WR: begin
                case (r_ret)
                    dsvs_pkg::RET_EDGE_V:
                        n_state = !r_colored[r_w] ? dsvs_pkg::S_R_ROW : dsvs_pkg::S_FIN;
                    dsvs_pkg::RET_COLOR:
                        n_state = dsvs_pkg::S_C_NEXT;
                    default:
                        n_state = dsvs_pkg::S_FIN;
                endcase
            end
            dsvs_pkg::S_C_RD:    n_state = dsvs_pkg::S_C_LATCH;
            dsvs_pkg::S_C_LATCH: n_state = dsvs_pkg::S_C_SCAN;
            dsvs_pkg::S_C_SCAN: begin
                if (r_nbrs[r_outer] && !r_colored[r_outer]) begin
                    n_state = dsvs_pkg::S_R_ROW;
                end else begin
                    n_state = dsvs_pkg::S_C_NEXT;
                end
            end
            dsvs_pkg::S_C_NEXT: begin
                n_state = (r_outer == dsvs_pkg::LAST_V) ? dsvs_pkg::S_FIN : dsvs_pkg::S_C_SCAN;
            end
            dsvs_pkg::S_S_SCAN: begin
                if (r_idx == dsvs_pkg::LAST_V) begin
                    n_state = dsvs_pkg::S_S_TAIL;
                end
            end
            dsvs_pkg::S_S_TAIL: n_state = dsvs_pkg::S_FIN;
            dsvs_pkg::S_FIN: begin
                if (out_free) begin
                    n_state = dsvs_pkg::S_IDLE;
                end
            end
            default: n_state = dsvs_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_present   = r_present;
        n_colored   = r_colored;
        n_adj_vld   = r_adj_vld;
        n_ds_vld    = r_ds_vld;
        n_out_valid = r_out_valid;
        n_v         = r_v;
        n_w         = r_w;
        n_idx       = r_idx;
        n_outer     = r_outer;
        n_tgt       = r_tgt;
        n_ret       = r_ret;
        n_row       = r_row;
        n_nbrs      = r_nbrs;
        n_seen      = r_seen;
        n_cnt       = r_cnt;
        n_q         = r_q;
        n_qv        = r_qv;
        n_qi        = r_qi;
        n_dup       = r_dup;
        n_found     = r_found;
        n_best      = r_best;
        n_bsat      = r_bsat;
        n_bdeg      = r_bdeg;
        n_sel       = r_sel;
        n_ofound    = r_ofound;
        n_oall      = r_oall;

        adj_we    = 1'b0;
        adj_waddr = r_v;
        adj_wdata = '0;
        adj_raddr = r_v;
        ds_we     = 1'b0;
        ds_waddr  = r_v;
        ds_wdata  = '0;
        ds_raddr  = r_v;
        col_we    = 1'b0;
        col_waddr = in_v;
        col_wdata = in_c;
        col_raddr = r_idx;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            dsvs_pkg::S_IDLE: begin
                if (acc) begin
                    n_v     = in_v;
                    n_w     = in_w;
                    n_idx   = '0;
                    n_qv    = 1'b0;
                    n_found = 1'b0;
                    n_best  = '0;
                    case (in_op)
                        dsvs_pkg::OP_CLEAR: begin
                            n_present = '0;
                            n_colored = '0;
                            n_adj_vld = '0;
                            n_ds_vld  = '0;
                        end
                        dsvs_pkg::OP_ADD_V: begin
                            n_present[in_v] = 1'b1;
                        end
                        dsvs_pkg::OP_EDGE: begin
                            if (in_v != in_w) begin
                                n_present[in_v] = 1'b1;
                                n_present[in_w] = 1'b1;
                            end
                        end
                        dsvs_pkg::OP_COLOR: begin
                            if (r_present[in_v]) begin
                                col_we            = 1'b1;
                                n_colored[in_v]   = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            dsvs_pkg::S_E_RDV: begin
                adj_raddr = r_v;
                ds_raddr  = r_v;
            end
            dsvs_pkg::S_E_WRV: begin
                n_dup     = adj_row[r_w];
                adj_raddr = r_w;
                ds_raddr  = r_w;
                if (!adj_row[r_w]) begin
                    adj_we         = 1'b1;
                    adj_waddr      = r_v;
                    adj_wdata      = adj_row | (NV'(1) << r_w);
                    n_adj_vld[r_v] = 1'b1;
                    ds_we          = 1'b1;
                    ds_waddr       = r_v;
                    ds_wdata       = {cand_deg + DEGW'(1), cand_sat};
                    n_ds_vld[r_v]  = 1'b1;
                end
            end
            dsvs_pkg::S_E_WRW: begin
                if (!r_dup) begin
                    adj_we         = 1'b1;
                    adj_waddr      = r_w;
                    adj_wdata      = adj_row | (NV'(1) << r_v);
                    n_adj_vld[r_w] = 1'b1;
                    ds_we          = 1'b1;
                    ds_waddr       = r_w;
                    ds_wdata       = {cand_deg + DEGW'(1), cand_sat};
                    n_ds_vld[r_w]  = 1'b1;
                end
                if (!r_colored[r_v]) begin
                    n_tgt = r_v;
                    n_ret = dsvs_pkg::RET_EDGE_V;
                end else begin
                    n_tgt = r_w;
                    n_ret = dsvs_pkg::RET_EDGE_W;
                end
            end
            dsvs_pkg::S_R_ROW: begin
                adj_raddr = r_tgt;
                n_idx     = '0;
                n_seen    = '0;
                n_cnt     = '0;
                n_qv      = 1'b0;
            end
            dsvs_pkg::S_R_LATCH: begin
                n_row = adj_row;
            end
            dsvs_pkg::S_R_SCAN, dsvs_pkg::S_R_TAIL: begin
                // issue color read for r_idx, count the color read last cycle
                col_raddr = r_idx;
                if (r_qv && r_q && !r_seen[col_rdata]) begin
                    n_seen[col_rdata] = 1'b1;
                    n_cnt             = r_cnt + SATW'(1);
                end
                if (r_state == dsvs_pkg::S_R_SCAN) begin
                    n_q   = r_row[r_idx] && r_colored[r_idx];
                    n_qv  = 1'b1;
                    n_idx = r_idx + VW'(1);
                end else begin
                    ds_raddr = r_tgt;
                end
            end
            dsvs_pkg::S_R_WR: begin
                ds_we            = 1'b1;
                ds_waddr         = r_tgt;
                ds_wdata         = {cand_deg, r_cnt};
                n_ds_vld[r_tgt]  = 1'b1;
                if (r_ret == dsvs_pkg::RET_EDGE_V) begin
                    n_tgt = r_w;
                    n_ret = dsvs_pkg::RET_EDGE_W;
                end
            end
            dsvs_pkg::S_C_RD: begin
                adj_raddr = r_v;
            end
            dsvs_pkg::S_C_LATCH: begin
                n_nbrs  = adj_row;
                n_outer = '0;
            end
            dsvs_pkg::S_C_SCAN: begin
                n_tgt = r_outer;
                n_ret = dsvs_pkg::RET_COLOR;
            end
            dsvs_pkg::S_C_NEXT: begin
                n_outer = r_outer + VW'(1);
            end
            dsvs_pkg::S_S_SCAN, dsvs_pkg::S_S_TAIL: begin
                // issue read for r_idx, compare the entry read last cycle
                ds_raddr = r_idx;
                if (r_qv && r_q && (!r_found || cand_sat > r_bsat ||
                                    (cand_sat == r_bsat && cand_deg > r_bdeg))) begin
                    n_found = 1'b1;
                    n_best  = r_qi;
                    n_bsat  = cand_sat;
                    n_bdeg  = cand_deg;
                end
                if (r_state == dsvs_pkg::S_S_SCAN) begin
                    n_q   = r_present[r_idx] && !r_colored[r_idx];
                    n_qi  = r_idx;
                    n_qv  = 1'b1;
                    n_idx = r_idx + VW'(1);
                end
            end
            dsvs_pkg::S_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_sel       = r_found ? r_best : '0;
                    n_ofound    = r_found;
                    n_oall      = ((r_present & ~r_colored) == '0);
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dsvs_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_present   <= '0;
            r_colored   <= '0;
            r_adj_vld   <= '0;
            r_ds_vld    <= '0;
            r_found     <= 1'b0;
            r_qv        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_present   <= n_present;
            r_colored   <= n_colored;
            r_adj_vld   <= n_adj_vld;
            r_ds_vld    <= n_ds_vld;
            r_found     <= n_found;
            r_qv        <= n_qv;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_v      <= n_v;
        r_w      <= n_w;
        r_idx    <= n_idx;
        r_outer  <= n_outer;
        r_tgt    <= n_tgt;
        r_ret    <= n_ret;
        r_row    <= n_row;
        r_nbrs   <= n_nbrs;
        r_seen   <= n_seen;
        r_cnt    <= n_cnt;
        r_q      <= n_q;
        r_qi     <= n_qi;
        r_dup    <= n_dup;
        r_best   <= n_best;
        r_bsat   <= n_bsat;
        r_bdeg   <= n_bdeg;
        r_sel    <= n_sel;
        r_ofound <= n_ofound;
        r_oall   <= n_oall;
        r_adj_rv <= r_adj_vld[adj_raddr];
        r_ds_rv  <= r_ds_vld[ds_raddr];
    end

endmodule

@@ bench/tb.sv @@
// Self-checking bench for the DSatur vertex selector against a behavioral graph model.
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic [2:0] op;
        logic [5:0] vtx;
        logic [5:0] nbr;
        logic [5:0] col;
    } cmd_t;

    typedef struct packed {
        logic [5:0] sel;
        logic       found;
        logic       all_col;
    } res_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata = '0;   // [5:0] vertex, [11:6] neighbor, [17:12] color
    logic [2:0]  i_s_tuser = '0;   // [2:0] operation
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [7:0]  o_m_tdata;        // [5:0] selected_vertex
    logic [1:0]  o_m_tuser;        // [0] vertex_found, [1] all_colored

    dsatur_vertex_selector_unit dut (.*);

    always #10 i_clk = ~i_clk;

    // graph model state
    logic [63:0] adj [64];
    logic [63:0] present, colored;
    logic [5:0]  vcolor [64];
    int unsigned degree [64];
    int unsigned satur [64];

    cmd_t pending_cmds [$];
    res_t expected_results [$];
    int   errors = 0;
    bit   calm = 0;          // no random idling
    int   hold_rx = 0;       // receiver hold-off cycles left
    bit   pause_tx = 0;      // sender offers no new commands

    function automatic void graph_clear();
        for (int i = 0; i < 64; i++) begin
            adj[i] = '0; vcolor[i] = '0; degree[i] = 0; satur[i] = 0;
        end
        present = '0; colored = '0;
    endfunction

    function automatic void refresh_saturation(int u);
        logic [63:0] seen;
        seen = '0;
        for (int n = 0; n < 64; n++)
            if (adj[u][n] && colored[n]) seen[vcolor[n]] = 1'b1;
        satur[u] = $countones(seen);
    endfunction

    function automatic res_t graph_apply(cmd_t c);
        res_t r;
        int best;
        r = '0;
        best = 0;
        case (c.op)
            dsvs_pkg::OP_CLEAR: graph_clear();
            dsvs_pkg::OP_ADD_V: if (!present[c.vtx]) begin
                present[c.vtx] = 1'b1; colored[c.vtx] = 1'b0;
                degree[c.vtx] = 0; satur[c.vtx] = 0;
            end
            dsvs_pkg::OP_EDGE: if (c.vtx != c.nbr) begin
                present[c.vtx] = 1'b1; present[c.nbr] = 1'b1;
                if (!adj[c.vtx][c.nbr]) begin
                    adj[c.vtx][c.nbr] = 1'b1; adj[c.nbr][c.vtx] = 1'b1;
                    degree[c.vtx]++; degree[c.nbr]++;
                end
                if (!colored[c.vtx]) refresh_saturation(c.vtx);
                if (!colored[c.nbr]) refresh_saturation(c.nbr);
            end
            dsvs_pkg::OP_COLOR: if (present[c.vtx]) begin
                vcolor[c.vtx] = c.col; colored[c.vtx] = 1'b1;
                for (int i = 0; i < 64; i++)
                    if (adj[c.vtx][i] && !colored[i]) refresh_saturation(i);
            end
            dsvs_pkg::OP_SELECT: for (int i = 0; i < 64; i++) begin
                if (present[i] && !colored[i] &&
                    (!r.found || satur[i] > satur[best] ||
                     (satur[i] == satur[best] && degree[i] > degree[best]))) begin
                    best = i; r.found = 1'b1;
                end
            end
            default: ;
        endcase
        if (r.found) r.sel = best[5:0];
        r.all_col = ((present & ~colored) == '0);
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    function automatic void enqueue_cmd(cmd_t c);
        pending_cmds = {pending_cmds, c};
    endfunction

    // driver: a transfer completes when tvalid and tready are both high
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_s_tvalid || o_s_tready) begin
                if (i_s_tvalid) begin
                    expected_results = {expected_results,
                                        graph_apply({i_s_tuser, i_s_tdata[5:0],
                                                     i_s_tdata[11:6], i_s_tdata[17:12]})};
                    void'(pending_cmds.pop_front());
                end
                if (pending_cmds.size() > 0 && !pause_tx &&
                    (calm || $urandom_range(99) >= 28)) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tuser  <= pending_cmds[0].op;
                    i_s_tdata  <= {6'd0, pending_cmds[0].col, pending_cmds[0].nbr,
                                   pending_cmds[0].vtx};
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        res_t want;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", o_m_tdata, -1);
                end else begin
                    want = expected_results.pop_front();
                    if (o_m_tdata[5:0] != want.sel)
                        report_mismatch("selected_vertex", o_m_tdata[5:0], want.sel);
                    if (o_m_tdata[7:6] != 2'b00)
                        report_mismatch("tdata padding", o_m_tdata[7:6], 0);
                    if (o_m_tuser[0] != want.found)
                        report_mismatch("vertex_found", o_m_tuser[0], want.found);
                    if (o_m_tuser[1] != want.all_col)
                        report_mismatch("all_colored", o_m_tuser[1], want.all_col);
                end
            end
        end
    end

    // receiver stall control: hold-off count, else random idling
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (hold_rx > 0) begin
                hold_rx <= hold_rx - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= calm || ($urandom_range(99) >= 28);
            end
        end
    end

    function automatic cmd_t mk(logic [2:0] op, int v, int n, int c);
        cmd_t x;
        x.op = op; x.vtx = v[5:0]; x.nbr = n[5:0]; x.col = c[5:0];
        return x;
    endfunction

    // random command mix over a vertex pool: edges, colorings and selects, with some clears, adds and unused op codes
    function automatic cmd_t rand_cmd(int pool);
        int k;
        k = $urandom_range(99);
        if (k < 3)  return mk(dsvs_pkg::OP_CLEAR, $urandom, $urandom, $urandom);
        if (k < 12) return mk(dsvs_pkg::OP_ADD_V, $urandom_range(pool), 0, 0);
        if (k < 45) return mk(dsvs_pkg::OP_EDGE, $urandom_range(pool), $urandom_range(pool),
                              $urandom);
        if (k < 68) return mk(dsvs_pkg::OP_COLOR, $urandom_range(pool), $urandom,
                              $urandom_range(pool % 8 + 1));
        if (k < 93) return mk(dsvs_pkg::OP_SELECT, $urandom, $urandom, $urandom);
        return mk(3'($urandom_range(7, 5)), $urandom, $urandom, $urandom);
    endfunction

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || i_s_tvalid || expected_results.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        graph_clear();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every op, each special case
        enqueue_cmd(mk(dsvs_pkg::OP_SELECT, 0, 0, 0));       // empty graph
        enqueue_cmd(mk(dsvs_pkg::OP_COLOR, 5, 0, 3));        // absent vertex
        enqueue_cmd(mk(dsvs_pkg::OP_ADD_V, 0, 0, 0));
        enqueue_cmd(mk(dsvs_pkg::OP_ADD_V, 63, 63, 63));
        enqueue_cmd(mk(dsvs_pkg::OP_ADD_V, 63, 0, 0));       // repeated add
        enqueue_cmd(mk(dsvs_pkg::OP_EDGE, 7, 7, 0));         // self-loop
        enqueue_cmd(mk(dsvs_pkg::OP_EDGE, 0, 63, 0));
        enqueue_cmd(mk(dsvs_pkg::OP_EDGE, 63, 0, 0));        // duplicate
        enqueue_cmd(mk(dsvs_pkg::OP_EDGE, 21, 42, 63));      // absent endpoints
        enqueue_cmd(mk(dsvs_pkg::OP_SELECT, 63, 63, 63));
        enqueue_cmd(mk(dsvs_pkg::OP_COLOR, 0, 0, 63));
        enqueue_cmd(mk(dsvs_pkg::OP_EDGE, 0, 42, 0));        // edge after coloring
        enqueue_cmd(mk(dsvs_pkg::OP_COLOR, 0, 0, 0));        // recolor
        enqueue_cmd(mk(dsvs_pkg::OP_COLOR, 42, 0, 0));
        enqueue_cmd(mk(dsvs_pkg::OP_SELECT, 0, 0, 0));
        enqueue_cmd(mk(3'd5, 63, 63, 63));
        enqueue_cmd(mk(3'd6, 0, 0, 0));
        enqueue_cmd(mk(3'd7, 42, 21, 42));
        enqueue_cmd(mk(dsvs_pkg::OP_COLOR, 63, 63, 21));
        enqueue_cmd(mk(dsvs_pkg::OP_COLOR, 21, 0, 42));
        enqueue_cmd(mk(dsvs_pkg::OP_SELECT, 0, 0, 0));       // all colored
        enqueue_cmd(mk(dsvs_pkg::OP_CLEAR, 63, 63, 63));
        enqueue_cmd(mk(dsvs_pkg::OP_SELECT, 0, 0, 0));
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        hold_rx = 400;
        for (int i = 0; i < 20; i++) enqueue_cmd(rand_cmd(15));
        wait_drained();

        // blocks of random commands, each drained, then a sender pause, repeatedly
        for (int blk = 0; blk < 26; blk++) begin
            calm = (blk >= 10 && blk < 14);
            for (int i = 0; i < 20; i++)
                enqueue_cmd(rand_cmd(blk % 3 == 0 ? 63 : 11));
            wait_drained();
            pause_tx = 1;
            repeat (3) @(posedge i_clk);
            pause_tx = 0;
        end
        calm = 0;
        wait_drained();
        repeat (600) @(posedge i_clk);
        if (errors == 0)
            $display("** dsatur_vertex_selector_unit: PASSED **");
        else
            $display("** dsatur_vertex_selector_unit: FAILED **");
        $finish;
    end

    initial begin
        #400ms;
        $display("** dsatur_vertex_selector_unit: FAILED **");
        $finish;
    end
endmodule
